FILE: sv/nus_pkg.sv
// Package for the nearest unused shift selector: widths, codes, state and command types.
`default_nettype none
package nus_pkg;

  localparam int MAX_CANDIDATES_DEF = 64;
  localparam int VALUE_WIDTH        = 32;
  localparam int CFG_W              = 7;
  localparam int IDX_W              = 6;
  localparam int STAT_W             = 2;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 8;

  localparam int OFS_IDX  = 0;
  localparam int OFS_VAL  = 6;
  localparam int OFS_STAT = 38;
  localparam int OFS_A    = 40;
  localparam int OFS_E    = 72;
  localparam int OFS_B    = 104;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] ST_UNUSED    = 2'd0;
  localparam logic [STAT_W-1:0] ST_USED      = 2'd1;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK0, S_MUL1, S_MUL2, S_SUM, S_SQRT, S_DIVI, S_DIV,
    S_SHIFT, S_SCAN1, S_SCAN2, S_FAIL, S_DONE
  } nus_state_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic mul_ee;
    logic mul_mm;
    logic sum;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic shift;
    logic scan_start;
    logic scan1;
    logic scan2;
    logic mark0;
    logic emit;
    logic emit_found;
  } nus_cmd_t;

  typedef struct packed {
    logic is_query;
    logic exhausted0;
    logic d_zero;
    logic step_last;
    logic scan_done;
    logic have;
    logic out_full;
  } nus_sts_t;

endpackage
`default_nettype wire

FILE: sv/nearest_unused_shift_select_top.sv
// Top level of the nearest unused shift selector.
//  channel | dir | fields
//  in_     | in  | tuser: req_type; tdata: entry_index, cand_value, cand_status, a, e, b
//  out_    | out | tuser: found; tdata: shift_index
//  cfg_    | in  | data: candidate_count
// Load: written into the table from idle. Query: check, two multiplies, sum, 32 sqrt
// steps, divide setup, 32 divide steps, shift (check goes straight to shift when a
// equals b), then two table scans over the n entries and one result state. A failed
// first scan skips the second and marks entry 0 exhausted; an exhausted entry 0 goes straight to the result.
// Reset (rst_n low, synchronous) clears the candidate count and the output valid flag.
// A finished word waits in the output register; the block holds in S_DONE while
// it is stalled and a new word is taken as soon as the previous result is queued.
`default_nettype none
module nearest_unused_shift_select_top #(
  parameter int MAX_CANDIDATES = nus_pkg::MAX_CANDIDATES_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // entry_index[5:0], cand_value[37:6], cand_status[39:38],
  // diag_a[71:40], offdiag[103:72], diag_b[135:104]
  input  wire  [nus_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire                             in_tuser,   // req_type[0]
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [nus_pkg::OUT_DATA_W-1:0]  out_tdata,  // shift_index[5:0]
  output logic                            out_tuser,  // found[0]
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [nus_pkg::CFG_W-1:0]       cfg_data    // candidate_count[6:0]
);
  import nus_pkg::*;

  nus_cmd_t cmd;
  nus_sts_t sts;

  assign cfg_ready = 1'b1;

  nus_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  nus_dp #(.MAX_CANDIDATES(MAX_CANDIDATES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

FILE: sv/nus_ctrl.sv
// Controller state machine sequencing loads, shift computation and table scans.
`default_nettype none
module nus_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  output logic               in_tready,
  input  wire                out_tready,
  input  nus_pkg::nus_sts_t  sts,
  output nus_pkg::nus_cmd_t  cmd
);
  import nus_pkg::*;

  nus_state_t state_r, state_nxt;
  logic       found_r, found_nxt;
  logic       acc;

  assign acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    found_nxt = found_r;
    unique case (state_r)
      S_IDLE:  if (acc && sts.is_query) state_nxt = S_CHK0;
      S_CHK0: begin
        found_nxt = 1'b0;
        if (sts.exhausted0) state_nxt = S_DONE;
        else if (sts.d_zero) state_nxt = S_SHIFT;
        else state_nxt = S_MUL1;
      end
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_SUM;
      S_SUM:   state_nxt = S_SQRT;
      S_SQRT:  if (sts.step_last) state_nxt = S_DIVI;
      S_DIVI:  state_nxt = S_DIV;
      S_DIV:   if (sts.step_last) state_nxt = S_SHIFT;
      S_SHIFT: state_nxt = S_SCAN1;
      S_SCAN1: if (sts.scan_done) state_nxt = sts.have ? S_SCAN2 : S_FAIL;
      S_SCAN2: begin
        if (sts.scan_done) begin
          found_nxt = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_FAIL:  state_nxt = S_DONE;
      S_DONE:  if (!sts.out_full || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.load    = acc && !sts.is_query;
        cmd.capture = acc && sts.is_query;
      end
      S_CHK0:  ;
      S_MUL1:  cmd.mul_ee = 1'b1;
      S_MUL2:  cmd.mul_mm = 1'b1;
      S_SUM:   cmd.sum = 1'b1;
      S_SQRT:  cmd.sqrt_step = 1'b1;
      S_DIVI:  cmd.div_init = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_SHIFT: begin
        cmd.shift      = 1'b1;
        cmd.scan_start = 1'b1;
      end
      S_SCAN1: begin
        cmd.scan1      = 1'b1;
        cmd.scan_start = sts.scan_done;
      end
      S_SCAN2: cmd.scan2 = 1'b1;
      S_FAIL:  cmd.mark0 = 1'b1;
      S_DONE: begin
        cmd.emit       = !sts.out_full || out_tready;
        cmd.emit_found = found_r;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/nus_dp.sv
// Datapath: candidate table, multiplier, sqrt and divide steps, scan and output register.
`default_nettype none
module nus_dp #(
  parameter int MAX_CANDIDATES = nus_pkg::MAX_CANDIDATES_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  nus_pkg::nus_cmd_t                 cmd,
  output nus_pkg::nus_sts_t                 sts,
  input  wire  [nus_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire                               in_tuser,
  input  wire                               cfg_valid,
  input  wire  [nus_pkg::CFG_W-1:0]         cfg_data,
  input  wire                               out_tready,
  output logic                              out_tvalid,
  output logic [nus_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tuser
);
  import nus_pkg::*;

  localparam int IW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CW = $clog2(MAX_CANDIDATES + 1);
  localparam int NW = (CW > CFG_W) ? CW : CFG_W;
  localparam int VW = VALUE_WIDTH;

  logic [VW-1:0]     val_mem [MAX_CANDIDATES];
  logic [STAT_W-1:0] st_mem  [MAX_CANDIDATES];
  logic [VW-1:0]     rd_val_r;
  logic [STAT_W-1:0] rd_st_r;
  logic [IW-1:0]     raddr;

  logic [CFG_W-1:0]  cfg_count_r;
  logic [NW-1:0]     n_eff, cfg_ext, max_ext;

  logic signed [VW-1:0] b_r;
  logic signed [VW:0]   d_r;
  logic [VW-1:0]        ae_r;
  logic [VW-2:0]        m;
  logic [2*VW-1:0]      e2_r, mm_r, prod;
  logic [VW-1:0]        mul_x;

  logic [2*VW-1:0]      rad_r;
  logic [VW+1:0]        rem_r;
  logic [VW-1:0]        root_r;
  logic [VW:0]          den_r;
  logic [VW-1:0]        qlo_r;
  logic [4:0]           step_r;
  logic [VW+2:0]        sq_s, sq_t;
  logic [VW+1:0]        dv_s;

  logic signed [VW-1:0] shift_r;
  logic signed [VW+1:0] shift_w;
  logic signed [VW+1:0] addend;

  logic [NW-1:0]        scan_cnt_r;
  logic                 rv_r;
  logic [IW-1:0]        ridx_r;
  logic                 issue;
  logic                 have_r;
  logic [IW-1:0]        pick_r;
  logic [VW:0]          best_r, dist_w;
  logic signed [VW:0]   diff;

  logic                 load_ok;
  logic [IW-1:0]        waddr;

  logic                 out_vld_r;
  logic [IDX_W-1:0]     out_idx_r;
  logic                 out_found_r;

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) cfg_count_r <= '0;
    else if (cfg_valid) cfg_count_r <= cfg_data;
  end

  assign cfg_ext = NW'(cfg_count_r);
  assign max_ext = NW'(MAX_CANDIDATES);
  assign n_eff   = (cfg_ext > max_ext) ? max_ext : cfg_ext;

  // Table
  assign load_ok = cmd.load &&
                   (32'(in_tdata[OFS_IDX +: IDX_W]) < 32'(MAX_CANDIDATES));
  assign waddr   = cmd.mark0 ? '0 : IW'(in_tdata[OFS_IDX +: IDX_W]);
  assign issue   = (cmd.scan1 || cmd.scan2) && (scan_cnt_r < n_eff);
  assign raddr   = cmd.capture ? '0 : scan_cnt_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (load_ok) val_mem[waddr] <= in_tdata[OFS_VAL +: VW];
    rd_val_r <= val_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (load_ok) st_mem[waddr] <= in_tdata[OFS_STAT +: STAT_W];
    else if (cmd.mark0) st_mem[waddr] <= ST_EXHAUSTED;
    rd_st_r <= st_mem[raddr];
  end

  // Operands
  assign m     = d_r[VW] ? (VW-1)'((-d_r) >> 1) : (VW-1)'(d_r >> 1);
  assign mul_x = cmd.mul_ee ? ae_r : {1'b0, m};
  assign prod  = mul_x * mul_x;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      b_r  <= in_tdata[OFS_B +: VW];
      d_r  <= {in_tdata[OFS_A+VW-1], in_tdata[OFS_A +: VW]} -
              {in_tdata[OFS_B+VW-1], in_tdata[OFS_B +: VW]};
      ae_r <= in_tdata[OFS_E+VW-1] ? (~in_tdata[OFS_E +: VW] + 1'b1)
                                   : in_tdata[OFS_E +: VW];
    end
    if (cmd.mul_ee) e2_r <= prod;
    if (cmd.mul_mm) mm_r <= prod;
  end

  // Sqrt and divide steps
  assign sq_s = {rem_r[VW:0], rad_r[2*VW-1 -: 2]};
  assign sq_t = {1'b0, root_r, 2'b01};
  assign dv_s = {rem_r[VW:0], qlo_r[VW-1]};

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      rad_r  <= mm_r + e2_r;
      rem_r  <= '0;
      root_r <= '0;
      step_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r  <= {rad_r[2*VW-3:0], 2'b00};
      step_r <= step_r + 5'd1;
      if (sq_s >= sq_t) begin
        rem_r  <= (VW+2)'(sq_s - sq_t);
        root_r <= {root_r[VW-2:0], 1'b1};
      end else begin
        rem_r  <= (VW+2)'(sq_s);
        root_r <= {root_r[VW-2:0], 1'b0};
      end
    end else if (cmd.div_init) begin
      den_r  <= {2'b00, m} + {1'b0, root_r};
      rem_r  <= {2'b00, e2_r[2*VW-1:VW]};
      qlo_r  <= e2_r[VW-1:0];
      step_r <= '0;
    end else if (cmd.div_step) begin
      step_r <= step_r + 5'd1;
      if (dv_s >= {1'b0, den_r}) begin
        rem_r <= dv_s - {1'b0, den_r};
        qlo_r <= {qlo_r[VW-2:0], 1'b1};
      end else begin
        rem_r <= dv_s;
        qlo_r <= {qlo_r[VW-2:0], 1'b0};
      end
    end
  end

  // Shift with saturation
  always_comb begin
    if (d_r == '0) addend = -$signed({2'b00, ae_r});
    else if (e2_r == '0) addend = '0;
    else if (d_r[VW]) addend = $signed({2'b00, qlo_r});
    else addend = -$signed({2'b00, qlo_r});
    shift_w = {{2{b_r[VW-1]}}, b_r} + addend;
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      if (shift_w[VW+1:VW-1] == 3'b000 || shift_w[VW+1:VW-1] == 3'b111)
        shift_r <= shift_w[VW-1:0];
      else if (shift_w[VW+1])
        shift_r <= {1'b1, {(VW-1){1'b0}}};
      else
        shift_r <= {1'b0, {(VW-1){1'b1}}};
    end
  end

  // Scans
  assign diff   = {shift_r[VW-1], shift_r} - {rd_val_r[VW-1], rd_val_r};
  assign dist_w = diff[VW] ? (VW+1)'(-diff) : (VW+1)'(diff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r       <= 1'b0;
      scan_cnt_r <= '0;
    end else if (cmd.scan_start) begin
      rv_r       <= 1'b0;
      scan_cnt_r <= '0;
    end else begin
      rv_r <= issue;
      if (issue) scan_cnt_r <= scan_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) ridx_r <= scan_cnt_r[IW-1:0];
    if (cmd.shift) have_r <= 1'b0;
    if (cmd.scan1 && rv_r && rd_st_r == ST_UNUSED) begin
      have_r <= 1'b1;
      pick_r <= ridx_r;
      best_r <= dist_w;
    end
    if (cmd.scan2 && rv_r && rd_st_r != ST_USED && dist_w < best_r) begin
      pick_r <= ridx_r;
      best_r <= dist_w;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (cmd.emit) out_vld_r <= 1'b1;
    else if (out_tready) out_vld_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_idx_r   <= cmd.emit_found ? IDX_W'(pick_r) : '0;
      out_found_r <= cmd.emit_found;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DATA_W'(out_idx_r);
  assign out_tuser  = out_found_r;

  assign sts.is_query   = (in_tuser == REQ_QUERY);
  assign sts.exhausted0 = (rd_st_r == ST_EXHAUSTED);
  assign sts.d_zero     = (d_r == '0);
  assign sts.step_last  = (step_r == 5'd31);
  assign sts.scan_done  = !rv_r && (scan_cnt_r >= n_eff);
  assign sts.have       = have_r;
  assign sts.out_full   = out_vld_r;

endmodule
`default_nettype wire

FILE: sv/nus_checker.sv
// Port-level checker for the nearest unused shift selector, with its bind.
`default_nettype none
module nus_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_tvalid,
  input wire                            in_tready,
  input wire                            in_tuser,
  input wire                            out_tvalid,
  input wire                            out_tready,
  input wire [nus_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire                            out_tuser
);
  import nus_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("failed query carries nonzero index");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == REQ_LOAD |=> in_tready)
    else $error("load word did not return to ready");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == REQ_QUERY |=> !in_tready)
    else $error("query word did not hold off input");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

endmodule

bind nearest_unused_shift_select_top nus_checker u_nus_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
